FILE: sv/pott_pkg.sv
// Shared types and codes for the priority-ordered task table.
`default_nettype none
package pott_pkg;

    localparam int HandlerWidth  = 32;
    localparam int PriorityWidth = 8;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_DEL  = 2'd1,
        OP_FIND = 2'd2,
        OP_LIST = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_MISS  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // Per-field write enables of one table entry
    typedef struct packed {
        logic handler;
        logic prio;
        logic prev;
        logic next;
    } t_fmask;

endpackage
`default_nettype wire

FILE: sv/pott_mem.sv
// Task entry memory: handler, priority and both links, field write enables.
`default_nettype none
module pott_mem
    import pott_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int LW    = 5
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire t_fmask                   i_wmask,
    input  wire logic [AW-1:0]            i_waddr,
    input  wire logic [HandlerWidth-1:0]  i_whandler,
    input  wire logic [PriorityWidth-1:0] i_wprio,
    input  wire logic [LW-1:0]            i_wprev,
    input  wire logic [LW-1:0]            i_wnext,
    input  wire logic                     i_re,
    input  wire logic [AW-1:0]            i_raddr,
    output logic [HandlerWidth-1:0]       o_handler,
    output logic [PriorityWidth-1:0]      o_prio,
    output logic [LW-1:0]                 o_prev,
    output logic [LW-1:0]                 o_next
);

    logic [HandlerWidth-1:0]  r_handler [DEPTH];
    logic [PriorityWidth-1:0] r_prio    [DEPTH];
    logic [LW-1:0]            r_prev    [DEPTH];
    logic [LW-1:0]            r_next    [DEPTH];

    // Write selected fields of one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            if (i_wmask.handler) r_handler[i_waddr] <= i_whandler;
            if (i_wmask.prio)    r_prio[i_waddr]    <= i_wprio;
            if (i_wmask.prev)    r_prev[i_waddr]    <= i_wprev;
            if (i_wmask.next)    r_next[i_waddr]    <= i_wnext;
        end
    end

    // Registered read, held when no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_handler <= r_handler[i_raddr];
            o_prio    <= r_prio[i_raddr];
            o_prev    <= r_prev[i_raddr];
            o_next    <= r_next[i_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: sv/priority_ordered_task_table_core.sv
// Priority-ordered task table: sequencer, slot occupancy bits and result register.
// Add: scan for the lowest free slot, walk the list links to the insert point, then link in.
// Delete: read the entry and unlink it; a free or out-of-range slot misses. Find: read each
// in-use entry and compare its handler. List: one result per cycle while the receiver takes
// them, after the head read; one request at a time. Reset clears the occupancy bits and empties
// the list at once; entry contents stay undefined until written.
`default_nettype none
module priority_ordered_task_table_core
    import pott_pkg::*;
#(
    parameter int TASK_SLOTS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_operation,
    input  wire logic [31:0] i_handler,
    input  wire logic [7:0]  i_priority_req,
    input  wire logic [3:0]  i_slot,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic [3:0]       o_slot_res,
    output logic [31:0]      o_handler_res,
    output logic [7:0]       o_priority_res,
    output logic             o_last
);

    localparam int IW       = $clog2(TASK_SLOTS);
    localparam int LW       = $clog2(TASK_SLOTS + 1);
    localparam int LIST_MAX = (TASK_SLOTS < 16) ? TASK_SLOTS : 16;
    localparam int CW       = $clog2(LIST_MAX + 1);
    localparam logic [LW-1:0] NONE    = LW'(TASK_SLOTS);
    localparam logic [IW-1:0] LAST_IX = IW'(TASK_SLOTS - 1);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_SCAN  = 12'b000000000010,
        S_ACMP  = 12'b000000000100,
        S_ALINK = 12'b000000001000,
        S_AFIX  = 12'b000000010000,
        S_DCMP  = 12'b000000100000,
        S_DFIX  = 12'b000001000000,
        S_FRD   = 12'b000010000000,
        S_FCMP  = 12'b000100000000,
        S_LEMIT = 12'b001000000000,
        S_RES   = 12'b010000000000,
        S_SPARE = 12'b100000000000
    } t_state;

    t_state                   r_state, n_state;
    logic [TASK_SLOTS-1:0]    r_in_use, n_in_use;
    logic [LW-1:0]            r_head, n_head;
    logic [HandlerWidth-1:0]  r_handler, n_handler;
    logic [PriorityWidth-1:0] r_pr, n_pr;
    logic [IW-1:0]            r_idx, n_idx;
    logic [IW-1:0]            r_ins, n_ins;
    logic [IW-1:0]            r_cur, n_cur;
    logic [LW-1:0]            r_lprev, n_lprev;
    logic [LW-1:0]            r_lnext, n_lnext;
    logic [CW-1:0]            r_cnt, n_cnt;
    t_status                  r_st, n_st;
    logic [IW-1:0]            r_sl, n_sl;
    logic                     r_ovld, n_ovld;
    t_status                  r_ostatus, n_ostatus;
    logic [3:0]               r_oslot, n_oslot;
    logic [HandlerWidth-1:0]  r_ohandler, n_ohandler;
    logic [PriorityWidth-1:0] r_oprio, n_oprio;
    logic                     r_olast, n_olast;

    logic                     m_we, m_re;
    t_fmask                   m_wmask;
    logic [IW-1:0]            m_waddr, m_raddr;
    logic [LW-1:0]            m_wprev, m_wnext;
    logic [HandlerWidth-1:0]  rd_h;
    logic [PriorityWidth-1:0] rd_p;
    logic [LW-1:0]            rd_prev, rd_next;
    logic                     out_free, fin, slot_bad;

    pott_mem #(.DEPTH(TASK_SLOTS), .AW(IW), .LW(LW)) u_mem (
        .i_clk      (i_clk),
        .i_we       (m_we),
        .i_wmask    (m_wmask),
        .i_waddr    (m_waddr),
        .i_whandler (r_handler),
        .i_wprio    (r_pr),
        .i_wprev    (m_wprev),
        .i_wnext    (m_wnext),
        .i_re       (m_re),
        .i_raddr    (m_raddr),
        .o_handler  (rd_h),
        .o_prio     (rd_p),
        .o_prev     (rd_prev),
        .o_next     (rd_next)
    );

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_ovld;
    assign o_status       = r_ostatus;
    assign o_slot_res     = r_oslot;
    assign o_handler_res  = r_ohandler;
    assign o_priority_res = r_oprio;
    assign o_last         = r_olast;

    assign out_free = !r_ovld || i_out_ready;
    assign fin      = (rd_next == NONE) || (r_cnt == CW'(LIST_MAX - 1));
    assign slot_bad = ({5'b0, i_slot} >= 9'(TASK_SLOTS)) || !r_in_use[IW'(i_slot)];

    // Sequence one request through the entry memory
    always_comb begin
        n_state    = r_state;
        n_in_use   = r_in_use;
        n_head     = r_head;
        n_handler  = r_handler;
        n_pr       = r_pr;
        n_idx      = r_idx;
        n_ins      = r_ins;
        n_cur      = r_cur;
        n_lprev    = r_lprev;
        n_lnext    = r_lnext;
        n_cnt      = r_cnt;
        n_st       = r_st;
        n_sl       = r_sl;
        n_ovld     = r_ovld && !i_out_ready;
        n_ostatus  = r_ostatus;
        n_oslot    = r_oslot;
        n_ohandler = r_ohandler;
        n_oprio    = r_oprio;
        n_olast    = r_olast;
        m_we       = 1'b0;
        m_wmask    = '0;
        m_waddr    = r_ins;
        m_wprev    = NONE;
        m_wnext    = NONE;
        m_re       = 1'b0;
        m_raddr    = r_cur;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_handler = i_handler;
                    n_pr      = i_priority_req;
                    n_idx     = '0;
                    case (t_op'(i_operation))
                        OP_ADD:  n_state = S_SCAN;
                        OP_DEL: begin
                            if (slot_bad) begin
                                n_st    = ST_MISS;
                                n_sl    = '0;
                                n_state = S_RES;
                            end else begin
                                n_sl    = IW'(i_slot);
                                n_in_use[IW'(i_slot)] = 1'b0;
                                m_re    = 1'b1;
                                m_raddr = IW'(i_slot);
                                n_state = S_DCMP;
                            end
                        end
                        OP_FIND: n_state = S_FRD;
                        default: begin
                            if (r_head == NONE) begin
                                n_st    = ST_EMPTY;
                                n_sl    = '0;
                                n_state = S_RES;
                            end else begin
                                n_cur   = r_head[IW-1:0];
                                n_cnt   = '0;
                                m_re    = 1'b1;
                                m_raddr = r_head[IW-1:0];
                                n_state = S_LEMIT;
                            end
                        end
                    endcase
                end
            end
            // Find the lowest free slot and store the task contents
            S_SCAN: begin
                if (!r_in_use[r_idx]) begin
                    n_ins           = r_idx;
                    m_we            = 1'b1;
                    m_waddr         = r_idx;
                    m_wmask.handler = 1'b1;
                    m_wmask.prio    = 1'b1;
                    if (r_head == NONE) begin
                        m_wmask.prev    = 1'b1;
                        m_wmask.next    = 1'b1;
                        n_in_use[r_idx] = 1'b1;
                        n_head          = LW'(r_idx);
                        n_st            = ST_OK;
                        n_sl            = r_idx;
                        n_state         = S_RES;
                    end else begin
                        n_cur   = r_head[IW-1:0];
                        m_re    = 1'b1;
                        m_raddr = r_head[IW-1:0];
                        n_state = S_ACMP;
                    end
                end else if (r_idx == LAST_IX) begin
                    n_st    = ST_FULL;
                    n_sl    = '0;
                    n_state = S_RES;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            // Walk the list to the first task of equal or greater priority
            S_ACMP: begin
                if (rd_p < r_pr) begin
                    if (rd_next == NONE) begin
                        n_lprev = LW'(r_cur);
                        n_lnext = NONE;
                        n_state = S_ALINK;
                    end else begin
                        n_cur   = rd_next[IW-1:0];
                        m_re    = 1'b1;
                        m_raddr = rd_next[IW-1:0];
                    end
                end else begin
                    m_we         = 1'b1;
                    m_waddr      = r_cur;
                    m_wmask.prev = 1'b1;
                    m_wprev      = LW'(r_ins);
                    n_lprev      = rd_prev;
                    n_lnext      = LW'(r_cur);
                    n_state      = S_ALINK;
                end
            end
            // Link the new entry and mark it in use
            S_ALINK: begin
                m_we            = 1'b1;
                m_wmask.prev    = 1'b1;
                m_wmask.next    = 1'b1;
                m_wprev         = r_lprev;
                m_wnext         = r_lnext;
                n_in_use[r_ins] = 1'b1;
                n_st            = ST_OK;
                n_sl            = r_ins;
                if (r_lprev == NONE) begin
                    n_head  = LW'(r_ins);
                    n_state = S_RES;
                end else begin
                    n_state = S_AFIX;
                end
            end
            S_AFIX: begin
                m_we         = 1'b1;
                m_waddr      = r_lprev[IW-1:0];
                m_wmask.next = 1'b1;
                m_wnext      = LW'(r_ins);
                n_state      = S_RES;
            end
            // Unlink a deleted entry from its neighbours
            S_DCMP: begin
                n_lprev = rd_prev;
                n_lnext = rd_next;
                if (rd_prev != NONE) begin
                    m_we         = 1'b1;
                    m_waddr      = rd_prev[IW-1:0];
                    m_wmask.next = 1'b1;
                    m_wnext      = rd_next;
                end else begin
                    n_head = rd_next;
                end
                n_state = S_DFIX;
            end
            S_DFIX: begin
                if (r_lnext != NONE) begin
                    m_we         = 1'b1;
                    m_waddr      = r_lnext[IW-1:0];
                    m_wmask.prev = 1'b1;
                    m_wprev      = r_lprev;
                end
                n_st    = ST_OK;
                n_state = S_RES;
            end
            // Scan in-use slots for a matching handler
            S_FRD: begin
                if (r_in_use[r_idx]) begin
                    m_re    = 1'b1;
                    m_raddr = r_idx;
                    n_state = S_FCMP;
                end else if (r_idx == LAST_IX) begin
                    n_st    = ST_MISS;
                    n_sl    = '0;
                    n_state = S_RES;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_FCMP: begin
                if (rd_h == r_handler) begin
                    n_st    = ST_OK;
                    n_sl    = r_idx;
                    n_state = S_RES;
                end else if (r_idx == LAST_IX) begin
                    n_st    = ST_MISS;
                    n_sl    = '0;
                    n_state = S_RES;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_FRD;
                end
            end
            // Emit one listed task per free output slot
            S_LEMIT: begin
                if (out_free) begin
                    n_ovld     = 1'b1;
                    n_ostatus  = ST_OK;
                    n_oslot    = 4'(r_cur);
                    n_ohandler = rd_h;
                    n_oprio    = rd_p;
                    n_olast    = fin;
                    if (fin) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cur   = rd_next[IW-1:0];
                        n_cnt   = r_cnt + 1'b1;
                        m_re    = 1'b1;
                        m_raddr = rd_next[IW-1:0];
                    end
                end
            end
            // Hand over a single result
            S_RES: begin
                if (out_free) begin
                    n_ovld     = 1'b1;
                    n_ostatus  = r_st;
                    n_oslot    = 4'(r_sl);
                    n_ohandler = '0;
                    n_oprio    = '0;
                    n_olast    = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_in_use <= '0;
            r_head   <= NONE;
            r_ovld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_in_use <= n_in_use;
            r_head   <= n_head;
            r_ovld   <= n_ovld;
        end
    end

    // Working and result payload
    always_ff @(posedge i_clk) begin
        r_handler  <= n_handler;
        r_pr       <= n_pr;
        r_idx      <= n_idx;
        r_ins      <= n_ins;
        r_cur      <= n_cur;
        r_lprev    <= n_lprev;
        r_lnext    <= n_lnext;
        r_cnt      <= n_cnt;
        r_st       <= n_st;
        r_sl       <= n_sl;
        r_ostatus  <= n_ostatus;
        r_oslot    <= n_oslot;
        r_ohandler <= n_ohandler;
        r_oprio    <= n_oprio;
        r_olast    <= n_olast;
    end

endmodule
`default_nettype wire

FILE: test/tb_priority_ordered_task_table_core.sv
// Testbench for the priority-ordered task table: directed table plus random requests.
`timescale 1ns / 100ps
`default_nettype none
module tb_priority_ordered_task_table_core;
    import pott_pkg::*;

    localparam int NumSlots = 16;
    localparam logic [4:0] NoLink = 5'd16;

    typedef struct {
        t_op         op;
        logic [31:0] handler;
        logic [7:0]  prio;
        logic [3:0]  slot;
        logic        typed;     // expected result typed in below
        t_status     st;
        logic [3:0]  res_slot;
    } t_row;

    typedef struct {
        t_status     st;
        logic [3:0]  slot;
        logic [31:0] handler;
        logic [7:0]  prio;
        logic        last;
    } t_res;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  operation = '0;
    logic [31:0] handler = '0;
    logic [7:0]  priority_req = '0;
    logic [3:0]  slot = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [3:0]  slot_res;
    logic [31:0] handler_res;
    logic [7:0]  priority_res;
    logic        last;

    // Predictor copy of the table
    logic        busy_q [NumSlots];
    logic [31:0] hnd_q  [NumSlots];
    logic [7:0]  pri_q  [NumSlots];
    logic [4:0]  prv_q  [NumSlots];
    logic [4:0]  nxt_q  [NumSlots];

    t_res        pending_results [$];
    int          n_errors = 0;
    int          n_results = 0;
    int          n_requests = 0;
    int          n_lists = 0;

    priority_ordered_task_table_core #(.TASK_SLOTS(NumSlots)) u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_operation(operation), .i_handler(handler),
        .i_priority_req(priority_req), .i_slot(slot),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_status(status), .o_slot_res(slot_res), .o_handler_res(handler_res),
        .o_priority_res(priority_res), .o_last(last)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    initial begin
        #50_000_000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        begin
            $display("Mismatch %s at result %0d: got %0h, want %0h", what, n_results, got, want);
            n_errors++;
        end
    endtask

    function automatic int find_head();
        int c;
        begin
            for (c = 0; c < NumSlots; c++)
                if (busy_q[c] && prv_q[c] == NoLink) return c;
            return NumSlots;
        end
    endfunction

    function automatic t_res mk(t_status st, int s, logic [31:0] h, logic [7:0] p, logic l);
        t_res r;
        begin
            r.st = st; r.slot = s[3:0]; r.handler = h; r.prio = p; r.last = l;
            return r;
        end
    endfunction

    // Link a freshly written slot in front of the first equal or greater priority
    task automatic link_in(input int ins);
        int c;
        int steps;
        int pv;
        begin
            c = find_head();
            if (c >= NumSlots) begin
                prv_q[ins] = NoLink; nxt_q[ins] = NoLink;
                return;
            end
            for (steps = 0; steps < NumSlots && pri_q[c] < pri_q[ins]; steps++) begin
                if (nxt_q[c] >= NoLink) begin
                    nxt_q[c] = 5'(ins); prv_q[ins] = 5'(c); nxt_q[ins] = NoLink;
                    return;
                end
                c = nxt_q[c];
            end
            pv = prv_q[c];
            prv_q[ins] = 5'(pv); nxt_q[ins] = 5'(c);
            if (pv < NumSlots) nxt_q[pv] = 5'(ins);
            prv_q[c] = 5'(ins);
        end
    endtask

    // Advance the table and queue the results one request causes
    task automatic predict_tasks(input t_op op, input logic [31:0] h, input logic [7:0] p,
                                 input logic [3:0] s);
        int c;
        int k;
        int pv;
        int nx;
        logic fin;
        begin
            case (op)
                OP_ADD: begin
                    for (c = 0; c < NumSlots; c++) if (!busy_q[c]) break;
                    if (c == NumSlots) begin
                        pending_results.push_back(mk(ST_FULL, 0, '0, '0, 1'b1));
                    end else begin
                        hnd_q[c] = h; pri_q[c] = p;
                        link_in(c);
                        busy_q[c] = 1'b1;
                        pending_results.push_back(mk(ST_OK, c, '0, '0, 1'b1));
                    end
                end
                OP_DEL: begin
                    if (!busy_q[s]) begin
                        pending_results.push_back(mk(ST_MISS, 0, '0, '0, 1'b1));
                    end else begin
                        busy_q[s] = 1'b0;
                        pv = prv_q[s]; nx = nxt_q[s];
                        if (pv < NumSlots) nxt_q[pv] = 5'(nx);
                        if (nx < NumSlots) prv_q[nx] = 5'(pv);
                        pending_results.push_back(mk(ST_OK, s, '0, '0, 1'b1));
                    end
                end
                OP_FIND: begin
                    for (c = 0; c < NumSlots; c++) if (busy_q[c] && hnd_q[c] == h) break;
                    if (c == NumSlots) pending_results.push_back(mk(ST_MISS, 0, '0, '0, 1'b1));
                    else pending_results.push_back(mk(ST_OK, c, '0, '0, 1'b1));
                end
                default: begin
                    n_lists++;
                    c = find_head();
                    if (c >= NumSlots) begin
                        pending_results.push_back(mk(ST_EMPTY, 0, '0, '0, 1'b1));
                    end else begin
                        for (k = 0; k < NumSlots; k++) begin
                            nx = nxt_q[c];
                            fin = (nx >= NumSlots) || (k + 1 == NumSlots);
                            pending_results.push_back(mk(ST_OK, c, hnd_q[c], pri_q[c], fin));
                            if (fin) break;
                            c = nx;
                        end
                    end
                end
            endcase
        end
    endtask

    // Hand one request over, holding valid until accepted
    task automatic send_request(input t_op op, input logic [31:0] h, input logic [7:0] p,
                                input logic [3:0] s);
        begin
            in_valid <= 1'b1;
            operation <= op; handler <= h; priority_req <= p; slot <= s;
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            predict_tasks(op, h, p, s);
            n_requests++;
        end
    endtask

    // Receiver stall pattern: quiet stretches, light stalling and heavy stalling take turns
    initial begin
        int phase;
        phase = 0;
        forever begin
            @(posedge clk);
            phase++;
            if ((phase / 300) % 3 == 0) out_ready <= 1'b1;
            else if ((phase / 300) % 3 == 1) out_ready <= ($urandom_range(0, 3) != 0);
            else out_ready <= ($urandom_range(0, 4) == 0);
        end
    end

    // Compare every accepted result with the oldest expectation
    always @(posedge clk) begin
        t_res w;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                report("unexpected result slot", 32'(slot_res), '0);
            end else begin
                w = pending_results.pop_front();
                if (status !== w.st) report("status", status, w.st);
                if (slot_res !== w.slot) report("slot", slot_res, w.slot);
                if (handler_res !== w.handler) report("handler", handler_res, w.handler);
                if (priority_res !== w.prio) report("priority", priority_res, w.prio);
                if (last !== w.last) report("last", last, w.last);
            end
            n_results++;
        end
    end

    t_row rows [$];
    task automatic add_row(input t_op op, input logic [31:0] h, input logic [7:0] p,
                           input logic [3:0] s, input logic typed, input t_status st,
                           input logic [3:0] rs);
        t_row r;
        begin
            r.op = op; r.handler = h; r.prio = p; r.slot = s;
            r.typed = typed; r.st = st; r.res_slot = rs;
            rows.push_back(r);
        end
    endtask

    initial begin
        int i;
        int n;
        int gap;
        int busy_count;
        t_op op;
        logic [31:0] h;
        t_res pr;
        for (i = 0; i < NumSlots; i++) begin
            busy_q[i] = 1'b0; hnd_q[i] = '0; pri_q[i] = '0; prv_q[i] = NoLink; nxt_q[i] = NoLink;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: empty cases, extremes, equal priorities, fill to full
        add_row(OP_LIST, '0, '0, '0, 1, ST_EMPTY, 0);
        add_row(OP_DEL, '0, '0, 4'd15, 1, ST_MISS, 0);
        add_row(OP_FIND, '0, '0, '0, 1, ST_MISS, 0);
        add_row(OP_ADD, 32'hFFFF_FFFF, 8'hFF, 4'd15, 1, ST_OK, 0);
        add_row(OP_ADD, 32'h0000_0000, 8'h00, 4'd0, 1, ST_OK, 1);
        add_row(OP_ADD, 32'hA5A5_5A5A, 8'hFE, 4'd0, 1, ST_OK, 2);
        add_row(OP_ADD, 32'h5A5A_A5A5, 8'hFE, 4'd0, 1, ST_OK, 3);
        add_row(OP_LIST, '0, '0, '0, 0, ST_OK, 0);
        add_row(OP_FIND, 32'h0000_0000, '0, '0, 1, ST_OK, 1);
        add_row(OP_DEL, '0, '0, 4'd1, 1, ST_OK, 1);
        add_row(OP_DEL, '0, '0, 4'd1, 1, ST_MISS, 0);
        add_row(OP_FIND, 32'h0000_0000, '0, '0, 1, ST_MISS, 0);
        add_row(OP_ADD, 32'h1234_5678, 8'h80, 4'd0, 1, ST_OK, 1);
        for (i = 4; i < NumSlots; i++) add_row(OP_ADD, 32'(i), 8'(i * 13), '0, 1, ST_OK, 4'(i));
        add_row(OP_ADD, 32'h0BAD_F00D, 8'h10, '0, 1, ST_FULL, 0);
        add_row(OP_LIST, '0, '0, '0, 0, ST_OK, 0);
        add_row(OP_DEL, '0, '0, 4'd0, 1, ST_OK, 0);

        // Typed rows cause a single result, the newest prediction
        foreach (rows[j]) begin
            send_request(rows[j].op, rows[j].handler, rows[j].prio, rows[j].slot);
            if (rows[j].typed) begin
                pr = pending_results[$];
                if (pr.st !== rows[j].st) report("directed row status", pr.st, rows[j].st);
                if (pr.slot !== rows[j].res_slot)
                    report("directed row slot", pr.slot, rows[j].res_slot);
            end
        end

        // Random bursts: mix adds, deletes, finds and lists to move the fill level around
        i = 0;
        while (i < 190) begin
            n = $urandom_range(1, 12);
            repeat (n) begin
                busy_count = 0;
                foreach (busy_q[k]) busy_count += busy_q[k];
                case ($urandom_range(0, 9))
                    0, 1, 2: op = (busy_count > 12 && $urandom_range(0, 1)) ? OP_DEL : OP_ADD;
                    3, 4, 5: op = OP_DEL;
                    6, 7:    op = OP_FIND;
                    default: op = OP_LIST;
                endcase
                h = ($urandom_range(0, 1)) ? $urandom() : 32'($urandom_range(0, 7));
                if (op == OP_FIND && busy_count > 0 && $urandom_range(0, 1))
                    h = hnd_q[$urandom_range(0, NumSlots - 1)];
                send_request(op, h, ($urandom_range(0, 1)) ? 8'($urandom()) :
                             8'($urandom_range(0, 3) * 85), 4'($urandom()));
                i++;
            end
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        $display("Sent %0d requests (%0d lists), checked %0d results", n_requests, n_lists,
                 n_results);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
